[design/obpc_pkg.sv]
package obpc_pkg;

  localparam int FRAC_BITS = 15;
  localparam int CHAN_W    = 16;
  localparam int ALPHA_W   = CHAN_W + 1;
  localparam int COL_W     = CHAN_W + 2;
  localparam int DVD_W     = COL_W + FRAC_BITS;
  localparam int DSR_W     = ALPHA_W;

  localparam logic [ALPHA_W-1:0] ONE = ALPHA_W'(1) << FRAC_BITS;

  // register indexes, byte address is index times four
  localparam logic [1:0] REG_CLAMP_LOW  = 2'd0;
  localparam logic [1:0] REG_CLAMP_HIGH = 2'd1;
  localparam logic [1:0] REG_ALPHA_TOL  = 2'd2;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [DVD_W-1:0]  dvd_t;
  typedef logic [DSR_W-1:0]  dsr_t;

endpackage

[design/over_blend_pixel_compositor.sv]
// Porter-Duff "over" blend of straight-alpha RGBA pixels in unsigned Q1.15.
// One pixel word is taken per clock while s_tready is high, and one result
// word leaves per clock while m_tready is high; a word passes through four
// arithmetic stages, a 33-stage divider that produces one quotient bit per
// stage, one clamp stage and the output register. A skid register sits
// behind the output register: when the output stalls with a word arriving,
// that word is parked and s_tready drops; once the output moves again the
// parked word goes first, and the pipe stands still while it leaves.
// Colours are divided by the result alpha only when it exceeds
// alpha_tolerance; all outputs are clamped to [clamp_low, clamp_high].
// Registers: clamp_low at 0x0, clamp_high at 0x4, alpha_tolerance at 0x8.
module over_blend_pixel_compositor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // base_red, base_green, base_blue, base_alpha, top_red, top_green,
  // top_blue, top_alpha, layer_opacity
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [63:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int FB     = obpc_pkg::FRAC_BITS;
  localparam int NDIV   = obpc_pkg::DVD_W;
  localparam int PIPE_N = 4 + NDIV + 1;

  obpc_pkg::chan_t clamp_low, clamp_high, alpha_tolerance;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_low       <= '0;
      clamp_high      <= obpc_pkg::CHAN_W'(obpc_pkg::ONE);
      alpha_tolerance <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        obpc_pkg::REG_CLAMP_LOW:  clamp_low       <= pwdata[15:0];
        obpc_pkg::REG_CLAMP_HIGH: clamp_high      <= pwdata[15:0];
        obpc_pkg::REG_ALPHA_TOL:  alpha_tolerance <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      obpc_pkg::REG_CLAMP_LOW:  prdata = 32'(clamp_low);
      obpc_pkg::REG_CLAMP_HIGH: prdata = 32'(clamp_high);
      obpc_pkg::REG_ALPHA_TOL:  prdata = 32'(alpha_tolerance);
      default:                  prdata = '0;
    endcase
  end

  logic en;
  logic [PIPE_N-1:0] vld;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_N-2:0], s_tvalid};
    end
  end

  // stage 1: top alpha times opacity, base colour times base alpha
  logic [31:0] s1_ta;
  logic [31:0] s1_bb [3];
  obpc_pkg::chan_t s1_ba;
  obpc_pkg::chan_t s1_top [3];

  // stage 2: effective alpha and its complement
  obpc_pkg::chan_t s2_eff, s2_comp, s2_ba;
  logic [31:0] s2_bb [3];
  obpc_pkg::chan_t s2_top [3];

  // stage 3: products with eff and comp
  obpc_pkg::chan_t s3_eff;
  logic [31:0] s3_te [3];
  logic [31:0] s3_bac;
  logic [47:0] s3_bbc [3];

  // stage 4: sums and divider operands
  obpc_pkg::dvd_t s4_dvd [3];
  obpc_pkg::dsr_t s4_dsr;
  logic [obpc_pkg::ALPHA_W-1:0] s4_alpha;

  logic [obpc_pkg::ALPHA_W:0] eff_wide;
  logic [obpc_pkg::ALPHA_W-1:0] alpha_sum;
  logic [obpc_pkg::COL_W-1:0] col_sum [3];

  always_comb begin
    eff_wide  = (obpc_pkg::ALPHA_W+1)'(s1_ta[31:FB]);
    alpha_sum = obpc_pkg::ALPHA_W'(s3_eff) + obpc_pkg::ALPHA_W'(s3_bac[30:FB]);
    for (int k = 0; k < 3; k++) begin
      col_sum[k] = obpc_pkg::COL_W'(s3_te[k][31:FB])
                 + obpc_pkg::COL_W'(s3_bbc[k][47:2*FB]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ta <= 32'(s_tdata[127:112]) * 32'(s_tdata[143:128]);
      s1_ba <= s_tdata[63:48];
      for (int k = 0; k < 3; k++) begin
        s1_bb[k]  <= 32'(s_tdata[16*k +: 16]) * 32'(s_tdata[63:48]);
        s1_top[k] <= s_tdata[64 + 16*k +: 16];
      end

      if (eff_wide > 18'(obpc_pkg::ONE)) begin
        s2_eff  <= obpc_pkg::CHAN_W'(obpc_pkg::ONE);
        s2_comp <= '0;
      end else begin
        s2_eff  <= eff_wide[15:0];
        s2_comp <= obpc_pkg::CHAN_W'(obpc_pkg::ONE) - eff_wide[15:0];
      end
      s2_ba  <= s1_ba;
      s2_bb  <= s1_bb;
      s2_top <= s1_top;

      s3_eff <= s2_eff;
      s3_bac <= 32'(s2_ba) * 32'(s2_comp);
      for (int k = 0; k < 3; k++) begin
        s3_te[k]  <= 32'(s2_top[k]) * 32'(s2_eff);
        s3_bbc[k] <= 48'(s2_bb[k]) * 48'(s2_comp);
      end

      // an undivided colour goes through the divider over ONE
      s4_alpha <= alpha_sum;
      s4_dsr   <= (alpha_sum > obpc_pkg::ALPHA_W'(alpha_tolerance))
                  ? alpha_sum : obpc_pkg::ONE;
      for (int k = 0; k < 3; k++) begin
        s4_dvd[k] <= {col_sum[k], FB'(0)};
      end
    end
  end

  obpc_pkg::dvd_t quo [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    obpc_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend (s4_dvd[k]),
      .divisor  (s4_dsr),
      .quotient (quo[k])
    );
  end

  logic [obpc_pkg::ALPHA_W-1:0] alpha_line [NDIV];

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_line[0] <= s4_alpha;
      for (int i = 1; i < NDIV; i++) begin
        alpha_line[i] <= alpha_line[i-1];
      end
    end
  end

  function automatic obpc_pkg::chan_t clamp_val(obpc_pkg::dvd_t v,
                                                obpc_pkg::chan_t lo,
                                                obpc_pkg::chan_t hi);
    obpc_pkg::chan_t r;
    if (v < obpc_pkg::DVD_W'(lo)) begin
      r = lo;
    end else if (v > obpc_pkg::DVD_W'(hi)) begin
      r = hi;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [63:0] cl_word;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cl_word[16*k +: 16] <= clamp_val(quo[k], clamp_low, clamp_high);
      end
      cl_word[63:48] <= clamp_val(obpc_pkg::DVD_W'(alpha_line[NDIV-1]),
                                  clamp_low, clamp_high);
    end
  end

  // output register with skid stage behind it
  logic [63:0] skid_word;
  logic last_valid;

  assign last_valid = vld[PIPE_N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= last_valid;
      end
    end else if (last_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_valid ? skid_word : cl_word;
    end else if (last_valid && en) begin
      skid_word <= cl_word;
    end
  end

endmodule

[design/obpc_div.sv]
module obpc_div (
  input  logic             clk,
  input  logic             en,
  input  obpc_pkg::dvd_t   dividend,
  input  obpc_pkg::dsr_t   divisor,
  output obpc_pkg::dvd_t   quotient
);

  localparam int NB = obpc_pkg::DVD_W;
  localparam int RW = obpc_pkg::DSR_W;

  logic [RW-1:0] rem_s [NB+1];
  logic [NB-1:0] dvd_s [NB+1];
  logic [NB-1:0] quo_s [NB+1];
  logic [RW-1:0] dsr_s [NB+1];

  assign rem_s[0] = '0;
  assign dvd_s[0] = dividend;
  assign quo_s[0] = '0;
  assign dsr_s[0] = divisor;

  // one quotient bit per stage, restoring form
  for (genvar g = 0; g < NB; g++) begin : g_stage
    logic [RW:0]   trial;
    logic          fits;
    logic [RW-1:0] rem_next;

    always_comb begin
      trial    = {rem_s[g], dvd_s[g][NB-1]};
      fits     = trial >= {1'b0, dsr_s[g]};
      rem_next = fits ? RW'(trial - {1'b0, dsr_s[g]}) : trial[RW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1] <= rem_next;
        dvd_s[g+1] <= {dvd_s[g][NB-2:0], 1'b0};
        quo_s[g+1] <= {quo_s[g][NB-2:0], fits};
        dsr_s[g+1] <= dsr_s[g];
      end
    end
  end

  assign quotient = quo_s[NB];

endmodule
